// ===== src/sq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Scale quantizer package
// Shared constants, register indexes, result type and pitch-class helper.
// ----------------------------------------------------------------------------
package sq_pkg;

    localparam int PITCH_W           = 7;
    localparam int CLASS_W           = 4;
    localparam int OCTAVE            = 12;
    localparam int PITCH_MAX         = 127;
    localparam int OFFSETS_W         = 48;
    localparam int LENGTH_W          = 4;
    localparam int CFG_INDEX_W       = 2;
    localparam int MAX_SCALE_NOTES_D = 12;

    localparam logic [CFG_INDEX_W-1:0] REG_ROOT_NOTE     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SCALE_OFFSETS = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SCALE_LENGTH  = 2'd2;

    typedef struct packed {
        logic [PITCH_W-1:0] pitch;
        logic               already;
        logic               no_match;
    } sq_result_t;

    // Pitch class of a 7-bit pitch: reciprocal multiply, then one correction.
    function automatic logic [CLASS_W-1:0] mod_octave(input logic [PITCH_W-1:0] x);
        logic [12:0] prod;
        logic [3:0]  quot;
        logic [7:0]  rem;
        prod = 13'(x) * 13'd43;
        quot = prod[12:9];
        rem  = {1'b0, x} - (8'(quot) * 8'd12);
        if (rem >= 8'(OCTAVE))
        begin
            rem = rem - 8'(OCTAVE);
        end
        return rem[CLASS_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== src/scale_quantizer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Scale quantizer
// Snaps pitch numbers to the nearest tone of a configured musical scale.
// ----------------------------------------------------------------------------
// A request is issued by raising start with pitch_in; it is taken at any
// clock edge where start is high and busy is low. Busy never rises, so one
// request can be issued in every cycle.
// The request is held in an input register while the
// membership test and the nearest-tone search run, and the result is
// captured in the result register. The result appears on pitch_out,
// already_in_scale and no_match with done high for exactly one cycle,
// and is taken at the edge that ends that cycle.
// Throughput is one request per cycle, set by the single search stage
// between the two registers.
// The receiver cannot stall; each result is shown for one cycle only.
// Configuration writes use cfg_valid, cfg_ready, cfg_index and cfg_data;
// cfg_ready is always high and indexes beyond the scale length register
// are ignored. Reset clears the configuration to an empty scale and drops
// any request in flight.
// ----------------------------------------------------------------------------
module scale_quantizer
#(
    parameter int MAX_SCALE_NOTES = sq_pkg::MAX_SCALE_NOTES_D
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    output      logic                            busy,
    input  wire logic [sq_pkg::PITCH_W-1:0]      pitch_in,
    output      logic                            done,
    output      logic [sq_pkg::PITCH_W-1:0]      pitch_out,
    output      logic                            already_in_scale,
    output      logic                            no_match,
    input  wire logic                            cfg_valid,
    output      logic                            cfg_ready,
    input  wire logic [sq_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [sq_pkg::OFFSETS_W-1:0]    cfg_data
);

    logic [sq_pkg::PITCH_W-1:0]   root_note_reg;
    logic [sq_pkg::OFFSETS_W-1:0] scale_offsets_reg;
    logic [sq_pkg::LENGTH_W-1:0]  scale_length_reg;

    logic                         in_valid_reg;
    logic [sq_pkg::PITCH_W-1:0]   pitch_reg;
    logic                         done_reg;
    sq_pkg::sq_result_t           result_reg;
    sq_pkg::sq_result_t           result_next;

    logic [sq_pkg::LENGTH_W-1:0]  len_eff;
    logic [sq_pkg::OCTAVE-1:0]    class_mask;
    logic [sq_pkg::CLASS_W-1:0]   root_mod;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_note_reg     <= '0;
            scale_offsets_reg <= '0;
            scale_length_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                sq_pkg::REG_ROOT_NOTE:
                begin
                    root_note_reg <= cfg_data[sq_pkg::PITCH_W-1:0];
                end
                sq_pkg::REG_SCALE_OFFSETS:
                begin
                    scale_offsets_reg <= cfg_data;
                end
                sq_pkg::REG_SCALE_LENGTH:
                begin
                    scale_length_reg <= cfg_data[sq_pkg::LENGTH_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        logic [sq_pkg::CLASS_W-1:0] off;
        if (scale_length_reg > sq_pkg::LENGTH_W'(MAX_SCALE_NOTES))
        begin
            len_eff = sq_pkg::LENGTH_W'(MAX_SCALE_NOTES);
        end
        else
        begin
            len_eff = scale_length_reg;
        end
        class_mask = '0;
        for (int i = 0; i < sq_pkg::OCTAVE; i++)
        begin
            off = scale_offsets_reg[4*i +: 4];
            if ((sq_pkg::LENGTH_W'(i) < len_eff) && (off < sq_pkg::CLASS_W'(sq_pkg::OCTAVE)))
            begin
                class_mask[off] = 1'b1;
            end
        end
        root_mod = sq_pkg::mod_octave(root_note_reg);
    end

    sq_search u_search
    (
        .class_mask (class_mask),
        .root_mod   (root_mod),
        .pitch      (pitch_reg),
        .result     (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
            done_reg     <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            pitch_reg <= pitch_in;
        end
        if (in_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign done             = done_reg;
    assign pitch_out        = result_reg.pitch;
    assign already_in_scale = result_reg.already;
    assign no_match         = result_reg.no_match;

endmodule
`default_nettype wire

// ===== src/sq_search.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Scale quantizer search
// Tests scale membership and finds the nearest member within one octave.
// ----------------------------------------------------------------------------
module sq_search
(
    input  wire logic [sq_pkg::OCTAVE-1:0]  class_mask,
    input  wire logic [sq_pkg::CLASS_W-1:0] root_mod,
    input  wire logic [sq_pkg::PITCH_W-1:0] pitch,
    output sq_pkg::sq_result_t              result
);

    logic [sq_pkg::CLASS_W-1:0]    pc;
    logic [sq_pkg::CLASS_W-1:0]    rel;
    logic [2*sq_pkg::OCTAVE-1:0]   dbl_mask;
    logic [sq_pkg::OCTAVE-1:0]     rot_mask;
    logic [sq_pkg::OCTAVE:1]       lo_hit;
    logic [sq_pkg::OCTAVE:1]       hi_hit;

    always_comb
    begin
        pc = sq_pkg::mod_octave(pitch);
        if (pc >= root_mod)
        begin
            rel = pc - root_mod;
        end
        else
        begin
            rel = pc + sq_pkg::CLASS_W'(sq_pkg::OCTAVE) - root_mod;
        end
        dbl_mask = {class_mask, class_mask};
        rot_mask = sq_pkg::OCTAVE'(dbl_mask >> rel);
    end

    always_comb
    begin
        for (int d = 1; d <= sq_pkg::OCTAVE; d++)
        begin
            lo_hit[d] = ({1'b0, pitch} >= 8'(d))
                        && rot_mask[(sq_pkg::OCTAVE - d) % sq_pkg::OCTAVE];
            hi_hit[d] = (({1'b0, pitch} + 8'(d)) <= 8'(sq_pkg::PITCH_MAX))
                        && rot_mask[d % sq_pkg::OCTAVE];
        end
    end

    always_comb
    begin
        logic found;
        logic [sq_pkg::PITCH_W-1:0] best;
        found = 1'b0;
        best  = pitch;
        for (int d = 1; d <= sq_pkg::OCTAVE; d++)
        begin
            if (!found)
            begin
                if (lo_hit[d])
                begin
                    best  = pitch - sq_pkg::PITCH_W'(d);
                    found = 1'b1;
                end
                else if (hi_hit[d])
                begin
                    best  = pitch + sq_pkg::PITCH_W'(d);
                    found = 1'b1;
                end
            end
        end

        result.pitch    = pitch;
        result.already  = 1'b0;
        result.no_match = 1'b1;
        if (class_mask != '0)
        begin
            if (rot_mask[0])
            begin
                result.already  = 1'b1;
                result.no_match = 1'b0;
            end
            else if (found)
            begin
                result.pitch    = best;
                result.no_match = 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

// ===== verif/sq_checker.sv =====
// ----------------------------------------------------------------------------
// Scale quantizer checker
// Watches the request, result and configuration channels of the scale
// quantizer. It keeps its own copy of the scale registers, works out the
// expected result of every accepted request and compares each result, field
// by field, with the oldest expectation still waiting.
// ----------------------------------------------------------------------------
module sq_checker
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic                           busy,
    input  wire logic [sq_pkg::PITCH_W-1:0]     pitch_in,
    input  wire logic                           done,
    input  wire logic [sq_pkg::PITCH_W-1:0]     pitch_out,
    input  wire logic                           already_in_scale,
    input  wire logic                           no_match,
    input  wire logic                           cfg_valid,
    input  wire logic                           cfg_ready,
    input  wire logic [sq_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [sq_pkg::OFFSETS_W-1:0]   cfg_data,
    output int                                  mismatches,
    output int                                  outstanding
);

    logic [sq_pkg::PITCH_W-1:0]   root_q;
    logic [sq_pkg::OFFSETS_W-1:0] offsets_q;
    logic [sq_pkg::LENGTH_W-1:0]  length_q;
    sq_pkg::sq_result_t           expected_q[$];
    int                           errors;

    function automatic logic [sq_pkg::OCTAVE-1:0] scale_classes();
        logic [sq_pkg::OCTAVE-1:0] classes;
        int                        count;
        int                        entry;
        classes = '0;
        count = (int'(length_q) > sq_pkg::OCTAVE) ? sq_pkg::OCTAVE : int'(length_q);
        for (int i = 0; i < count; i++)
        begin
            entry = int'(offsets_q[4*i +: 4]);
            if (entry < sq_pkg::OCTAVE)
            begin
                classes[entry] = 1'b1;
            end
        end
        return classes;
    endfunction

    function automatic bit on_scale(input logic [sq_pkg::OCTAVE-1:0] classes,
                                    input int pitch);
        int step;
        step = (pitch % sq_pkg::OCTAVE + sq_pkg::OCTAVE - int'(root_q) % sq_pkg::OCTAVE)
               % sq_pkg::OCTAVE;
        return classes[step];
    endfunction

    function automatic sq_pkg::sq_result_t quantize(input logic [sq_pkg::PITCH_W-1:0] pitch);
        sq_pkg::sq_result_t        res;
        logic [sq_pkg::OCTAVE-1:0] classes;
        int                        p;
        classes = scale_classes();
        p = int'(pitch);
        res.pitch = pitch;
        res.already = 1'b0;
        res.no_match = 1'b1;
        if (classes != '0)
        begin
            if (on_scale(classes, p))
            begin
                res.already = 1'b1;
                res.no_match = 1'b0;
            end
            else
            begin
                for (int d = 1; d <= sq_pkg::OCTAVE && res.no_match; d++)
                begin
                    if (p >= d && on_scale(classes, p - d))
                    begin
                        res.pitch = sq_pkg::PITCH_W'(p - d);
                        res.no_match = 1'b0;
                    end
                    else if (p + d <= sq_pkg::PITCH_MAX && on_scale(classes, p + d))
                    begin
                        res.pitch = sq_pkg::PITCH_W'(p + d);
                        res.no_match = 1'b0;
                    end
                end
            end
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        sq_pkg::sq_result_t want;
        if (!rst_n)
        begin
            root_q      <= '0;
            offsets_q   <= '0;
            length_q    <= '0;
            expected_q.delete();
            errors = 0;
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (start && !busy)
            begin
                expected_q.push_back(quantize(pitch_in));
            end
            if (done)
            begin
                if (expected_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: result with no request waiting: expected none, actual pitch %0d",
                             $time, pitch_out);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (pitch_out !== want.pitch)
                    begin
                        errors++;
                        $display("%0t: pitch_out mismatch: expected %0d, actual %0d",
                                 $time, want.pitch, pitch_out);
                    end
                    if (already_in_scale !== want.already)
                    begin
                        errors++;
                        $display("%0t: already_in_scale mismatch: expected %0b, actual %0b",
                                 $time, want.already, already_in_scale);
                    end
                    if (no_match !== want.no_match)
                    begin
                        errors++;
                        $display("%0t: no_match mismatch: expected %0b, actual %0b",
                                 $time, want.no_match, no_match);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    sq_pkg::REG_ROOT_NOTE:     root_q    <= cfg_data[sq_pkg::PITCH_W-1:0];
                    sq_pkg::REG_SCALE_OFFSETS: offsets_q <= cfg_data;
                    sq_pkg::REG_SCALE_LENGTH:  length_q  <= cfg_data[sq_pkg::LENGTH_W-1:0];
                    default:                   ;
                endcase
            end
            mismatches  <= errors;
            outstanding <= expected_q.size();
        end
    end

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// Scale quantizer testbench
// Drives pitch requests in random bursts against a series of scale settings,
// starting with directed pitches on hand-picked scales and then moving on to
// random scales and pitches. The checker beside the block predicts and
// compares every result; this module only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module testbench;

    localparam logic [sq_pkg::CFG_INDEX_W-1:0] REG_SPARE = 2'd3;
    localparam int PHASES          = 12;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int TAIL_CYCLES     = 4;

    logic                           clk;
    logic                           rst_n;
    logic                           start;
    logic                           busy;
    logic [sq_pkg::PITCH_W-1:0]     pitch_in;
    logic                           done;
    logic [sq_pkg::PITCH_W-1:0]     pitch_out;
    logic                           already_in_scale;
    logic                           no_match;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [sq_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [sq_pkg::OFFSETS_W-1:0]   cfg_data;
    int                             mismatches;
    int                             outstanding;
    int                             cycles = 0;
    int                             pitches_sent = 0;
    int                             settings = 0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    scale_quantizer i_dut
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .pitch_in         (pitch_in),
        .done             (done),
        .pitch_out        (pitch_out),
        .already_in_scale (already_in_scale),
        .no_match         (no_match),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    sq_checker i_checker
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .pitch_in         (pitch_in),
        .done             (done),
        .pitch_out        (pitch_out),
        .already_in_scale (already_in_scale),
        .no_match         (no_match),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .mismatches       (mismatches),
        .outstanding      (outstanding)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles.", cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic write_reg(input logic [sq_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [sq_pkg::OFFSETS_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic load_scale(input logic [sq_pkg::PITCH_W-1:0] root,
                              input logic [sq_pkg::OFFSETS_W-1:0] offsets,
                              input logic [sq_pkg::LENGTH_W-1:0] length, input bit spare);
        write_reg(sq_pkg::REG_ROOT_NOTE, sq_pkg::OFFSETS_W'(root));
        write_reg(sq_pkg::REG_SCALE_OFFSETS, offsets);
        write_reg(sq_pkg::REG_SCALE_LENGTH, sq_pkg::OFFSETS_W'(length));
        if (spare)
        begin
            write_reg(REG_SPARE, sq_pkg::OFFSETS_W'({$urandom, $urandom}));
        end
        cfg_valid <= 1'b0;
        settings++;
    endtask

    task automatic send_pitch(input logic [sq_pkg::PITCH_W-1:0] pitch);
        start    <= 1'b1;
        pitch_in <= pitch;
        do @(posedge clk); while (busy);
        pitches_sent++;
    endtask

    task automatic drain();
        start <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    initial
    begin
        logic [sq_pkg::OFFSETS_W-1:0] offsets;
        logic [sq_pkg::LENGTH_W-1:0]  length;
        logic [sq_pkg::PITCH_W-1:0]   root;
        int                           sent;
        int                           burst;
        int                           gap;

        rst_n     = 1'b0;
        start     = 1'b0;
        pitch_in  = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The scale is empty straight out of reset.
        send_pitch(7'd0);
        send_pitch(7'd127);
        send_pitch(7'd60);
        drain();

        load_scale(7'd0, 48'h0000_0B97_5420, 4'd7, 1'b0);
        send_pitch(7'd0);
        send_pitch(7'd127);
        send_pitch(7'd1);
        send_pitch(7'd6);
        send_pitch(7'd126);
        drain();

        // A single tone at the pitch class of the top pitch; the spare index must change nothing.
        load_scale(7'd127, 48'h0, 4'd1, 1'b1);
        send_pitch(7'd0);
        send_pitch(7'd1);
        send_pitch(7'd13);
        send_pitch(7'd120);
        send_pitch(7'd126);
        send_pitch(7'd127);
        drain();

        load_scale(7'd0, 48'hFFFF_FFFF_FFFF, 4'd12, 1'b0);
        send_pitch(7'd5);
        send_pitch(7'd127);
        drain();

        // Only the last entry holds a usable offset, so a length above twelve must reach it.
        load_scale(7'd0, 48'h3FFF_FFFF_FFFF, 4'd15, 1'b0);
        send_pitch(7'd0);
        send_pitch(7'd64);
        send_pitch(7'd127);
        drain();

        load_scale(7'd5, 48'hBA98_7654_3210, 4'd0, 1'b0);
        send_pitch(7'd7);
        send_pitch(7'd100);
        drain();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case ($urandom_range(0, 5))
                0: offsets = sq_pkg::OFFSETS_W'({$urandom, $urandom});
                1: offsets = '1;
                default:
                begin
                    for (int i = 0; i < sq_pkg::OCTAVE; i++)
                    begin
                        offsets[4*i +: 4] = ($urandom_range(0, 9) == 0) ?
                                            4'($urandom_range(12, 15)) : 4'($urandom_range(0, 11));
                    end
                end
            endcase
            case ($urandom_range(0, 7))
                0: length = '0;
                1: length = 4'($urandom_range(12, 15));
                default: length = 4'($urandom_range(1, 12));
            endcase
            case ($urandom_range(0, 5))
                0: root = '0;
                1: root = 7'd127;
                default: root = 7'($urandom_range(0, 127));
            endcase
            load_scale(root, offsets, length, $urandom_range(0, 3) == 0);

            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                burst = $urandom_range(1, 24);
                for (int k = 0; k < burst && sent < ITEMS_PER_PHASE; k++)
                begin
                    if ($urandom_range(0, 15) == 0)
                    begin
                        send_pitch($urandom_range(0, 1) ? 7'd127 : 7'd0);
                    end
                    else
                    begin
                        send_pitch(7'($urandom_range(0, 127)));
                    end
                    sent++;
                end
                if ($urandom_range(0, 9) == 0)
                begin
                    drain();
                end
                else
                begin
                    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    if (gap > 0)
                    begin
                        start <= 1'b0;
                        repeat (gap) @(posedge clk);
                    end
                end
            end
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Quantized %0d pitches across %0d scale settings, including empty scales,",
                 pitches_sent, settings);
        $display("oversized lengths, unusable offsets and both ends of the pitch range.");
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
